// ----- rtl/bf7_pkg.sv -----
// ============================================================================
// bf7_pkg: shared definitions for the 7x7 RGB bilateral filter
// Holds default parameters, field widths, command and kind codes, register
// indexes and the control bundle between the front and back ends.
// ============================================================================
package bf7_pkg;

    localparam int MAX_WIDTH_DEF        = 1024;
    localparam int RADIUS_DEF           = 3;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int IDX_W         = 8;
    localparam int ROW_W         = 16;
    localparam int IMG_W_W       = 11;
    localparam int IMG_H_W       = 16;
    localparam int CMD_W         = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int RANGE_DEPTH   = 256;
    localparam int SPATIAL_DEPTH = 16;
    localparam int SP_IDX_W      = 4;
    localparam int NCH           = 3;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd480;

    // Register indexes, taken from paddr[2].
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_PIXEL   = 2'd0,
        CMD_RANGE   = 2'd1,
        CMD_SPATIAL = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_RANGE   = 2'd1,
        KIND_SPATIAL = 2'd2
    } t_kind;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_q_ctl;

endpackage

// ----- rtl/bf7_front.sv -----
// ============================================================================
// bf7_front: input acceptance, classification and item queue
// Drops commands that do nothing, saturates table weights and queues the
// remaining transactions for the back end in a two-entry queue.
// ============================================================================
module bf7_front #(
    parameter int WGT_W = bf7_pkg::WEIGHT_FRAC_BITS_DEF + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bf7_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bf7_pkg::PIX_W-1:0]  i_pixel,
    input  logic [bf7_pkg::IDX_W-1:0]  i_index,
    input  logic [WGT_W-1:0]           i_weight,
    input  bf7_pkg::t_q_ctl            i_ctl,
    output logic                       o_q_valid,
    output bf7_pkg::t_kind             o_q_kind,
    output logic [bf7_pkg::PIX_W-1:0]  o_q_pixel,
    output logic [bf7_pkg::IDX_W-1:0]  o_q_index,
    output logic [WGT_W-1:0]           o_q_weight
);

    localparam logic [WGT_W-1:0] W_ONE = {1'b1, {(WGT_W-1){1'b0}}};
    localparam logic [1:0]       Q_FULL = 2'd2;

    bf7_pkg::t_kind              r_kind   [2];
    logic [bf7_pkg::PIX_W-1:0]   r_pixel  [2];
    logic [bf7_pkg::IDX_W-1:0]   r_index  [2];
    logic [WGT_W-1:0]            r_weight [2];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;

    bf7_pkg::t_cmd               cmd;
    bf7_pkg::t_kind              kind;
    logic                        keep;
    logic                        push;
    logic [WGT_W-1:0]            sat_weight;

    always_comb begin
        cmd  = bf7_pkg::t_cmd'(i_cmd);
        keep = 1'b0;
        kind = bf7_pkg::KIND_PIXEL;
        unique case (cmd)
            bf7_pkg::CMD_PIXEL: begin
                keep = 1'b1;
                kind = bf7_pkg::KIND_PIXEL;
            end
            bf7_pkg::CMD_RANGE: begin
                keep = 1'b1;
                kind = bf7_pkg::KIND_RANGE;
            end
            bf7_pkg::CMD_SPATIAL: begin
                // Entries past the end of the spatial table are dropped.
                keep = (i_index < bf7_pkg::IDX_W'(bf7_pkg::SPATIAL_DEPTH));
                kind = bf7_pkg::KIND_SPATIAL;
            end
            bf7_pkg::CMD_NONE: begin
                keep = 1'b0;
                kind = bf7_pkg::KIND_PIXEL;
            end
        endcase
        sat_weight = (i_weight > W_ONE) ? W_ONE : i_weight;
    end

    assign o_ready   = (r_cnt != Q_FULL) && !i_ctl.clearing;
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_kind  = r_kind[r_rp];
    assign o_q_pixel = r_pixel[r_rp];
    assign o_q_index = r_index[r_rp];
    assign o_q_weight = r_weight[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_ctl.pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, i_ctl.pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wp]   <= kind;
            r_pixel[r_wp]  <= i_pixel;
            r_index[r_wp]  <= i_index;
            r_weight[r_wp] <= sat_weight;
        end
    end

endmodule

// ----- rtl/bf7_div.sv -----
// ============================================================================
// bf7_div: serial restoring divider for one channel
// Produces an 8-bit quotient, one bit per cycle, most significant first.
// ============================================================================
module bf7_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 39
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [DEN_W-1:0]          i_den,
    output logic                      o_done,
    output logic [bf7_pkg::CH_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(bf7_pkg::CH_W);
    localparam int SH     = bf7_pkg::CH_W - 1;

    logic [NUM_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_dsh;
    logic [bf7_pkg::CH_W-1:0] r_q;
    logic [STEP_W-1:0]        r_step;
    logic                     r_busy;
    logic                     r_done;
    logic                     ge;

    assign ge     = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= NUM_W'(i_den) << SH;
            r_step <= STEP_W'(SH);
            r_q    <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q    <= {r_q[bf7_pkg::CH_W-2:0], ge};
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - STEP_W'(1);
        end
    end

endmodule

// ----- rtl/bf7_back.sv -----
// ============================================================================
// bf7_back: line stores, window, weight tables, multiply-add and division
// Carries out queued items: table writes, pixel window updates and, for
// interior pixels, the weighted sums over all taps and the final division.
// ============================================================================
module bf7_back #(
    parameter  int MAX_WIDTH        = bf7_pkg::MAX_WIDTH_DEF,
    parameter  int RADIUS           = bf7_pkg::RADIUS_DEF,
    parameter  int WEIGHT_FRAC_BITS = bf7_pkg::WEIGHT_FRAC_BITS_DEF,
    localparam int COL_W            = $clog2(MAX_WIDTH),
    localparam int WGT_W            = WEIGHT_FRAC_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  bf7_pkg::t_kind               i_q_kind,
    input  logic [bf7_pkg::PIX_W-1:0]    i_q_pixel,
    input  logic [bf7_pkg::IDX_W-1:0]    i_q_index,
    input  logic [WGT_W-1:0]             i_q_weight,
    output bf7_pkg::t_q_ctl              o_ctl,
    input  logic [bf7_pkg::IMG_W_W-1:0]  i_width,
    input  logic [bf7_pkg::IMG_H_W-1:0]  i_height,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bf7_pkg::ROW_W-1:0]    o_row,
    output logic [COL_W-1:0]             o_col,
    output logic [bf7_pkg::CH_W-1:0]     o_blue,
    output logic [bf7_pkg::CH_W-1:0]     o_green,
    output logic [bf7_pkg::CH_W-1:0]     o_red
);

    localparam int SIDE   = 2 * RADIUS + 1;
    localparam int LINES  = 2 * RADIUS;
    localparam int TAPS   = SIDE * SIDE;
    localparam int TAP_W  = $clog2(TAPS + 1);
    localparam int POS_W  = $clog2(SIDE);
    localparam int PROD_W = 2 * WEIGHT_FRAC_BITS + 1;
    localparam int DEN_W  = PROD_W + $clog2(TAPS);
    localparam int NUM_W  = DEN_W + bf7_pkg::CH_W;
    localparam int PX_W   = PROD_W + bf7_pkg::CH_W;
    localparam int LM_W   = LINES * bf7_pkg::PIX_W;
    localparam int PW     = bf7_pkg::PIX_W;
    localparam int CW     = bf7_pkg::CH_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LINE  = 6'b000100,
        S_MAC   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [COL_W-1:0]            r_clr;
    logic [COL_W-1:0]            r_col;
    logic [bf7_pkg::ROW_W-1:0]   r_row;
    logic [LM_W-1:0]             r_lm [MAX_WIDTH];
    logic [LM_W-1:0]             r_lm_rd;
    logic [LM_W-1:0]             lm_wdata;
    logic [COL_W-1:0]            lm_addr;
    logic                        lm_we;
    logic [PW-1:0]               r_win [TAPS];
    logic [PW-1:0]               r_tap [TAPS];
    logic [PW-1:0]               win_shift [TAPS];
    logic [PW-1:0]               r_centre;
    logic [bf7_pkg::ROW_W-1:0]   r_orow;
    logic [COL_W-1:0]            r_ocol;
    logic [WGT_W-1:0]            r_sp [bf7_pkg::SPATIAL_DEPTH];
    logic [TAP_W-1:0]            r_issue;
    logic [POS_W-1:0]            r_tx;
    logic [POS_W-1:0]            r_ty;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic [WGT_W-1:0]            r_s1;
    logic                        r_o_valid;
    logic [bf7_pkg::ROW_W-1:0]   r_o_row;
    logic [COL_W-1:0]            r_o_col;
    logic [CW-1:0]               r_o_ch [bf7_pkg::NCH];

    logic                        emit;
    logic                        col_last;
    logic                        row_last;
    logic                        range_we;
    logic                        sp_we;
    logic                        issue;
    logic                        mac_done;
    logic                        out_load;
    logic [POS_W-1:0]            dx;
    logic [POS_W-1:0]            dy;
    logic [POS_W+1:0]            sp_full;
    logic [bf7_pkg::SP_IDX_W-1:0] sidx;
    logic [CW-1:0]               res_ch  [bf7_pkg::NCH];
    logic                        done_ch [bf7_pkg::NCH];

    // ---- decode ----
    assign emit     = (r_row >= bf7_pkg::ROW_W'(LINES)) && (32'(r_col) >= LINES);
    assign col_last = (32'(r_col) + 32'd1) >= 32'(i_width);
    assign row_last = (32'(r_row) + 32'd1) >= 32'(i_height);
    assign range_we = (r_state == S_IDLE) && i_q_valid && (i_q_kind == bf7_pkg::KIND_RANGE);
    assign sp_we    = (r_state == S_IDLE) && i_q_valid && (i_q_kind == bf7_pkg::KIND_SPATIAL);
    assign issue    = (r_state == S_MAC) && (r_issue != TAP_W'(TAPS));
    assign mac_done = (r_state == S_MAC) && (r_issue == TAP_W'(TAPS)) && !r_v1 && !r_v2 && !r_v3;
    assign out_load = (r_state == S_OUT) && (!r_o_valid || i_ready);

    assign o_ctl.pop      = range_we || sp_we || (r_state == S_LINE);
    assign o_ctl.clearing = (r_state == S_CLEAR);

    assign dx      = (r_tx >= POS_W'(RADIUS)) ? r_tx - POS_W'(RADIUS) : POS_W'(RADIUS) - r_tx;
    assign dy      = (r_ty >= POS_W'(RADIUS)) ? r_ty - POS_W'(RADIUS) : POS_W'(RADIUS) - r_ty;
    assign sp_full = {dx, 2'b00} | {2'b00, dy};
    assign sidx    = sp_full[bf7_pkg::SP_IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == COL_W'(MAX_WIDTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && (i_q_kind == bf7_pkg::KIND_PIXEL)) begin
                    n_state = S_LINE;
                end
            end
            S_LINE: begin
                n_state = emit ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (mac_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (done_ch[0]) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- window and line store update ----
    always_comb begin
        for (int y = 0; y < SIDE; y++) begin
            for (int x = 0; x < SIDE - 1; x++) begin
                win_shift[y*SIDE+x] = r_win[y*SIDE+x+1];
            end
        end
        for (int y = 0; y < LINES; y++) begin
            win_shift[y*SIDE+SIDE-1] = r_lm_rd[y*PW +: PW];
        end
        win_shift[LINES*SIDE+SIDE-1] = i_q_pixel;
    end

    always_comb begin
        lm_wdata = '0;
        if (r_state == S_LINE) begin
            for (int y = 0; y < LINES - 1; y++) begin
                lm_wdata[y*PW +: PW] = r_lm_rd[(y+1)*PW +: PW];
            end
            lm_wdata[(LINES-1)*PW +: PW] = i_q_pixel;
        end
    end

    assign lm_we   = (r_state == S_CLEAR) || (r_state == S_LINE);
    assign lm_addr = (r_state == S_CLEAR) ? r_clr : r_col;

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            r_lm[lm_addr] <= lm_wdata;
        end
        r_lm_rd <= r_lm[r_col];
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_issue   <= '0;
            r_tx      <= '0;
            r_ty      <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + COL_W'(1);
            end
            if (r_state == S_LINE) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + bf7_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
                r_issue <= '0;
                r_tx    <= '0;
                r_ty    <= '0;
            end else if (issue) begin
                r_issue <= r_issue + TAP_W'(1);
                if (r_tx == POS_W'(SIDE - 1)) begin
                    r_tx <= '0;
                    r_ty <= r_ty + POS_W'(1);
                end else begin
                    r_tx <= r_tx + POS_W'(1);
                end
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (r_state == S_LINE) begin
            r_win    <= win_shift;
            r_centre <= win_shift[RADIUS*SIDE+RADIUS];
            r_orow   <= r_row - bf7_pkg::ROW_W'(RADIUS);
            r_ocol   <= r_col - COL_W'(RADIUS);
            if (emit) begin
                r_tap <= win_shift;
            end
        end else if (issue) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                r_tap[i] <= r_tap[i+1];
            end
        end
        if (sp_we) begin
            r_sp[i_q_index[bf7_pkg::SP_IDX_W-1:0]] <= i_q_weight;
        end
        r_s1 <= r_sp[sidx];
        if (out_load) begin
            r_o_row <= r_orow;
            r_o_col <= r_ocol;
            r_o_ch  <= res_ch;
        end
    end

    // ---- per-channel multiply-add pipeline and divider ----
    for (genvar c = 0; c < bf7_pkg::NCH; c++) begin : g_ch
        logic [WGT_W-1:0]   r_rmem [bf7_pkg::RANGE_DEPTH];
        logic [WGT_W-1:0]   r_rd;
        logic [CW-1:0]      nv;
        logic [CW-1:0]      cv;
        logic [CW-1:0]      diff;
        logic [CW-1:0]      r_nv1;
        logic [CW-1:0]      r_nv2;
        logic [2*WGT_W-1:0] w_full;
        logic [PROD_W-1:0]  r_w2;
        logic [PX_W-1:0]    r_p3;
        logic [DEN_W-1:0]   r_den;
        logic [NUM_W-1:0]   r_num;
        logic [CW-1:0]      quot;
        logic               done;

        assign nv     = r_tap[0][c*CW +: CW];
        assign cv     = r_centre[c*CW +: CW];
        assign diff   = (cv >= nv) ? cv - nv : nv - cv;
        assign w_full = r_s1 * r_rd;

        always_ff @(posedge i_clk) begin
            if (range_we) begin
                r_rmem[i_q_index] <= i_q_weight;
            end
            r_rd <= r_rmem[diff];
        end

        always_ff @(posedge i_clk) begin
            r_nv1 <= nv;
            r_nv2 <= r_nv1;
            r_w2  <= w_full[PROD_W-1:0];
            r_p3  <= PX_W'(r_w2) * PX_W'(r_nv2);
            if ((r_state == S_LINE) && emit) begin
                r_den <= '0;
                r_num <= '0;
            end else begin
                if (r_v2) begin
                    r_den <= r_den + DEN_W'(r_w2);
                end
                if (r_v3) begin
                    r_num <= r_num + NUM_W'(r_p3);
                end
            end
        end

        bf7_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (mac_done),
            .i_num   (r_num),
            .i_den   (r_den),
            .o_done  (done),
            .o_quot  (quot)
        );

        // A channel whose weights all vanish keeps the centre value.
        assign res_ch[c]  = (r_den == '0) ? cv : quot;
        assign done_ch[c] = done;
    end

    assign o_valid = r_o_valid;
    assign o_row   = r_o_row;
    assign o_col   = r_o_col;
    assign o_blue  = r_o_ch[0];
    assign o_green = r_o_ch[1];
    assign o_red   = r_o_ch[2];

endmodule

// ----- rtl/bilateral_filter_7x7_rgb.sv -----
// ============================================================================
// bilateral_filter_7x7_rgb: streaming 7x7 bilateral filter for RGB pixels
// Top level: stream ports, register port, front end, back end.
// ============================================================================
// Pixels enter in raster order on the slave stream with tuser = 0; tuser = 1
// loads one entry of the range weight table (index = intensity difference)
// and tuser = 2 one entry of the spatial table (index = dx*4+dy). Both tables
// hold unsigned Q1.16 weights and must be loaded before pixels are sent, as
// their contents are undefined until written. For every interior pixel whose
// 7x7 window is complete, one result transaction leaves on the master stream
// with the centre pixel's row and column and the three filtered channels;
// nothing is sent for the three-pixel border. After reset the line stores are
// cleared entry by entry (MAX_WIDTH entries, 1024 by default), during which
// tready stays low; register writes are taken throughout. A pixel that
// produces a result is picked up, updates the line stores and window, passes
// its 49 taps one at a time through the multiply-add pipelines (one per
// channel, side by side) and drains them, goes through the serial division
// (the three channels divide in parallel) and is loaded into the output
// register once it is free. A border pixel only updates the line stores and
// window, and a table entry is written as it is picked up. A two-entry queue
// lets the input keep accepting while the back end works, and an output
// register holds a finished result while the next pixel is processed. Width
// and height are clamped to at least 7 (width also to at most MAX_WIDTH) when
// written, and should be changed only while the block is idle.
// ============================================================================
module bilateral_filter_7x7_rgb #(
    parameter  int MAX_WIDTH        = bf7_pkg::MAX_WIDTH_DEF,
    parameter  int RADIUS           = bf7_pkg::RADIUS_DEF,
    parameter  int WEIGHT_FRAC_BITS = bf7_pkg::WEIGHT_FRAC_BITS_DEF,
    localparam int COL_W            = $clog2(MAX_WIDTH),
    localparam int WGT_W            = WEIGHT_FRAC_BITS + 1,
    localparam int IN_FIELDS        = 4 * bf7_pkg::CH_W + WGT_W,
    localparam int IN_DW            = ((IN_FIELDS + 7) / 8) * 8,
    localparam int OUT_FIELDS       = bf7_pkg::ROW_W + COL_W + bf7_pkg::PIX_W,
    localparam int OUT_DW           = ((OUT_FIELDS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // blue[7:0], green[15:8], red[23:16], table_index[31:24],
    // table_weight[32+:WGT_W], zero pad above.
    input  logic [IN_DW-1:0]              s_axis_tdata,
    // command[1:0].
    input  logic [bf7_pkg::CMD_W-1:0]     s_axis_tuser,
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_row[15:0], out_col[16+:COL_W], then out_blue, out_green, out_red,
    // zero pad above.
    output logic [OUT_DW-1:0]             m_axis_tdata,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bf7_pkg::PADDR_W-1:0]   paddr,
    input  logic [bf7_pkg::PDATA_W-1:0]   pwdata,
    output logic [bf7_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SIDE = 2 * RADIUS + 1;
    localparam int CW   = bf7_pkg::CH_W;
    localparam logic [bf7_pkg::IMG_W_W-1:0] W_MIN = bf7_pkg::IMG_W_W'(SIDE);
    localparam logic [bf7_pkg::IMG_W_W-1:0] W_MAX =
        (MAX_WIDTH > 2047) ? 11'd2047 : bf7_pkg::IMG_W_W'(MAX_WIDTH);
    localparam logic [bf7_pkg::IMG_H_W-1:0] H_MIN = bf7_pkg::IMG_H_W'(SIDE);

    logic [bf7_pkg::IMG_W_W-1:0] r_width;
    logic [bf7_pkg::IMG_H_W-1:0] r_height;
    logic [bf7_pkg::IMG_W_W-1:0] wr_width;
    logic [bf7_pkg::IMG_H_W-1:0] wr_height;
    logic                        cfg_wr;

    logic                        q_valid;
    bf7_pkg::t_kind              q_kind;
    logic [bf7_pkg::PIX_W-1:0]   q_pixel;
    logic [bf7_pkg::IDX_W-1:0]   q_index;
    logic [WGT_W-1:0]            q_weight;
    bf7_pkg::t_q_ctl             q_ctl;

    logic [bf7_pkg::ROW_W-1:0]   out_row;
    logic [COL_W-1:0]            out_col;
    logic [CW-1:0]               out_blue;
    logic [CW-1:0]               out_green;
    logic [CW-1:0]               out_red;

    // Register port: always ready, registers decoded on paddr[2].
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        wr_width = pwdata[bf7_pkg::IMG_W_W-1:0];
        if (wr_width < W_MIN) begin
            wr_width = W_MIN;
        end else if (wr_width > W_MAX) begin
            wr_width = W_MAX;
        end
        wr_height = pwdata[bf7_pkg::IMG_H_W-1:0];
        if (wr_height < H_MIN) begin
            wr_height = H_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bf7_pkg::WIDTH_RESET;
            r_height <= bf7_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == bf7_pkg::REG_WIDTH) begin
                r_width <= wr_width;
            end else begin
                r_height <= wr_height;
            end
        end
    end

    assign prdata = (paddr[2] == bf7_pkg::REG_WIDTH) ?
                    bf7_pkg::PDATA_W'(r_width) : bf7_pkg::PDATA_W'(r_height);

    // Front end: classifies transactions and queues them.
    bf7_front #(
        .WGT_W (WGT_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_pixel    (s_axis_tdata[bf7_pkg::PIX_W-1:0]),
        .i_index    (s_axis_tdata[bf7_pkg::PIX_W +: bf7_pkg::IDX_W]),
        .i_weight   (s_axis_tdata[4*CW +: WGT_W]),
        .i_ctl      (q_ctl),
        .o_q_valid  (q_valid),
        .o_q_kind   (q_kind),
        .o_q_pixel  (q_pixel),
        .o_q_index  (q_index),
        .o_q_weight (q_weight)
    );

    // Back end: window, tables, weighted sums and division.
    bf7_back #(
        .MAX_WIDTH        (MAX_WIDTH),
        .RADIUS           (RADIUS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_kind   (q_kind),
        .i_q_pixel  (q_pixel),
        .i_q_index  (q_index),
        .i_q_weight (q_weight),
        .o_ctl      (q_ctl),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_row      (out_row),
        .o_col      (out_col),
        .o_blue     (out_blue),
        .o_green    (out_green),
        .o_red      (out_red)
    );

    assign m_axis_tdata = OUT_DW'({out_red, out_green, out_blue, out_col, out_row});

endmodule

// ----- rtl/bf7_checker.sv -----
// ============================================================================
// bf7_checker: port-level checks for the bilateral filter
// Watches the top level's ports and is attached by the bind below.
// ============================================================================
module bf7_checker #(
    parameter int OUT_DW = 56
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata
);

    // A waiting result must not change or vanish.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the output and starts the line store clear.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("block not quiet after reset");

    // No pixel of the top or left border is reported.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] >= 16'd3) && (m_axis_tdata[25:16] >= 10'd3))
        else $error("border pixel reported");

endmodule

bind bilateral_filter_7x7_rgb bf7_checker #(.OUT_DW(OUT_DW)) u_bf7_checker (.*);

// ----- test/tb_bilateral_filter_7x7_rgb.sv -----
// ============================================================================
// tb_bilateral_filter_7x7_rgb: stream-level test of the 7x7 bilateral filter
// Loads the weight tables, streams small frames under several width and
// height settings with random idling on both sides, and checks every filtered
// pixel against a built-in model of the line stores, window and division.
// ============================================================================
`timescale 1ns / 100ps

// Scoreboard: mirrors the filter state and keeps a queue of expected pixels.
class bf7_scoreboard;
    bit [23:0] lines [6][1024];
    bit [23:0] win [7][7];
    bit [16:0] range_wt [256];
    bit [16:0] spatial_wt [16];
    int unsigned row_cnt, col_cnt, width, height;
    bit [49:0] pending [$];
    int errors;

    function new();
        width = 640;
        height = 480;
    endfunction

    function void set_width(int unsigned w);
        width = (w < 7) ? 7 : (w > 1024) ? 1024 : w;
    endfunction

    function void set_height(int unsigned h);
        height = (h < 7) ? 7 : h;
    endfunction

    // Filters one channel of the current window, starting at bit sh.
    function bit [7:0] filter_chan(int sh);
        bit [7:0] cv, nv;
        bit [63:0] num, den, w, q;
        int dx, dy, d;
        cv = win[3][3][sh+:8];
        num = 0;
        den = 0;
        for (int y = 0; y < 7; y++) begin
            for (int x = 0; x < 7; x++) begin
                nv = win[y][x][sh+:8];
                dy = (y > 3) ? y - 3 : 3 - y;
                dx = (x > 3) ? x - 3 : 3 - x;
                d = (cv > nv) ? cv - nv : nv - cv;
                w = 64'(spatial_wt[dx*4+dy]) * 64'(range_wt[d]);
                den += w;
                num += w * nv;
            end
        end
        if (den == 0) return cv;
        q = num / den;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Notes one accepted input transaction.
    function void note_input(bit [1:0] cmd, bit [63:0] data);
        bit [16:0] wt;
        bit [23:0] px;
        int c;
        wt = data[48:32];
        if (wt > 17'h10000) wt = 17'h10000;
        if (cmd == bf7_pkg::CMD_RANGE) begin
            range_wt[data[31:24]] = wt;
            return;
        end
        if (cmd == bf7_pkg::CMD_SPATIAL) begin
            if (data[31:24] < 16) spatial_wt[data[27:24]] = wt;
            return;
        end
        if (cmd != bf7_pkg::CMD_PIXEL) return;
        px = data[23:0];
        c = col_cnt % 1024;
        for (int y = 0; y < 7; y++)
            for (int x = 0; x < 6; x++) win[y][x] = win[y][x+1];
        for (int y = 0; y < 6; y++) win[y][6] = lines[y][c];
        win[6][6] = px;
        for (int y = 0; y < 5; y++) lines[y][c] = lines[y+1][c];
        lines[5][c] = px;
        if (row_cnt >= 6 && col_cnt >= 6)
            pending.push_back({filter_chan(16), filter_chan(8), filter_chan(0),
                               10'(col_cnt - 3), 16'(row_cnt - 3)});
        if (col_cnt + 1 >= width) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= height) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endfunction

    // Checks one accepted result transaction against the oldest expectation.
    function void check_result(bit [49:0] got);
        bit [49:0] exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            $display("%0t: mismatch row/col/b/g/r expected %0d %0d %0d %0d %0d",
                     $realtime, exp_r[15:0], exp_r[25:16], exp_r[33:26],
                     exp_r[41:34], exp_r[49:42]);
            $display("%0t: mismatch row/col/b/g/r actual   %0d %0d %0d %0d %0d",
                     $realtime, got[15:0], got[25:16], got[33:26], got[41:34],
                     got[49:42]);
            errors++;
        end
    endfunction
endclass

module tb_bilateral_filter_7x7_rgb;

    localparam int LIMIT = 2_000_000;
    localparam logic [2:0] ADDR_WIDTH  = {bf7_pkg::REG_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HEIGHT = {bf7_pkg::REG_HEIGHT, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // blue, green, red, table_index, table_weight
    logic [1:0]  s_axis_tuser = '0;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // out_row, out_col, out_blue, out_green, out_red
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bf7_scoreboard sb = new();
    int send_idle_pct, recv_idle_pct;
    longint cycles = 0;

    bilateral_filter_7x7_rgb dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random; every result transaction is checked here.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[49:0]);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Writes one register through a setup phase and then an access phase.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WIDTH) sb.set_width(value[10:0]);
        else sb.set_height(value[15:0]);
    endtask

    // Offers one transaction, idling first at random, and waits for its acceptance.
    // tvalid stays high after acceptance so that transactions can follow back to
    // back; the idle loop and drain() take it down.
    task automatic send(bf7_pkg::t_cmd cmd, logic [63:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data[55:0];
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(cmd, data);
    endtask

    task automatic send_pixel(logic [23:0] px);
        send(bf7_pkg::CMD_PIXEL, {32'h0, px});
    endtask

    task automatic send_table(bf7_pkg::t_cmd cmd, logic [7:0] idx, logic [16:0] wt);
        send(cmd, {7'h0, wt, idx, 24'h0});
    endtask

    // Stops sending, waits until all results are in, then lets the back end settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Weights for both tables, with some saturating entries. A full
    // load writes every range entry; a partial one rewrites random entries.
    task automatic load_tables(bit gaussian, int n_range);
        logic [7:0] idx;
        for (int i = 0; i < n_range; i++) begin
            idx = (n_range >= 256) ? i[7:0] : 8'($urandom_range(255));
            send_table(bf7_pkg::CMD_RANGE, idx, gaussian ? 17'(65536 >> (idx / 16)) :
                       17'($urandom_range(131071)));
        end
        for (int i = 0; i < 16; i++)
            send_table(bf7_pkg::CMD_SPATIAL, i[7:0], 17'($urandom_range(131071)));
    endtask

    // One whole frame of random pixels at the current size, sometimes smooth.
    task automatic send_frame(bit smooth);
        logic [23:0] base;
        base = $urandom;
        for (int n = 0; n < sb.width * sb.height; n++)
            send_pixel(smooth ? base ^ 24'($urandom_range(7) * 24'h010101) : 24'($urandom));
    endtask

    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 67;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full table load and directed table cases, then the smallest frame.
        write_reg(ADDR_WIDTH, 32'd7);
        write_reg(ADDR_HEIGHT, 32'd7);
        load_tables(1'b1, 256);
        send(bf7_pkg::CMD_NONE, {64{1'b1}});
        send_table(bf7_pkg::CMD_SPATIAL, 8'hff, 17'h1ffff);
        send_table(bf7_pkg::CMD_SPATIAL, 8'd16, 17'd0);
        send_table(bf7_pkg::CMD_RANGE, 8'hff, 17'h1ffff);
        send_pixel(24'hffffff);
        for (int n = 1; n < 49; n++) send_pixel((n % 2) ? 24'h000000 : 24'hffffff);
        drain();

        // Zero spatial weights everywhere: each channel falls back to its centre.
        for (int i = 0; i < 16; i++) send_table(bf7_pkg::CMD_SPATIAL, i[7:0], 17'd0);
        send_frame(1'b0);
        drain();

        // Out-of-range register values, which the block clamps.
        write_reg(ADDR_WIDTH, 32'd2);
        write_reg(ADDR_HEIGHT, 32'd0);
        load_tables(1'b0, 16);
        send_frame(1'b1);
        drain();

        // A tall image: rows run past seven without wrapping.
        write_reg(ADDR_HEIGHT, 32'hffff);
        for (int n = 0; n < 56; n++) send_pixel(24'($urandom));
        drain();

        // Random part: three idling regimes over varied small frames.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 11 : 0;
            write_reg(ADDR_WIDTH, 32'($urandom_range(7, 12)));
            write_reg(ADDR_HEIGHT, 32'($urandom_range(7, 10)));
            load_tables($urandom_range(1), 16);
            while (sb.row_cnt != 0 || sb.col_cnt != 0) send_pixel(24'($urandom));
            for (int f = 0; f < 2; f++) send_frame($urandom_range(1));
            drain();
        end

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/bf7_pkg.sv
rtl/bf7_front.sv
rtl/bf7_div.sv
rtl/bf7_back.sv
rtl/bilateral_filter_7x7_rgb.sv
rtl/bf7_checker.sv
test/tb_bilateral_filter_7x7_rgb.sv
